FILE: rtl/stable_priority_task_queue_unit_assert.svh
// Assertion macros shared by the stable priority task queue RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef STABLE_PRIORITY_TASK_QUEUE_UNIT_ASSERT_SVH
`define STABLE_PRIORITY_TASK_QUEUE_UNIT_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define SPQ_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: rtl/spq_pkg.sv
// Package for the stable priority task queue: sizes, operation and status codes,
// and the result word and cell control types. Depends on nothing else.
package spq_pkg;

  localparam int DEPTH  = 16;
  localparam int PRIO_W = 8;
  localparam int PAY_W  = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_STOP = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_PUSH_STOPPED = 3'd1,
    ST_PUSH_FULL    = 3'd2,
    ST_POP_EMPTY    = 3'd3,
    ST_POP_STOPPED  = 3'd4
  } status_t;

  // Shift commands broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

  typedef struct packed {
    status_t            status;
    logic [PRIO_W-1:0]  prio;
    logic [PAY_W-1:0]   payload;
    logic [CNT_W-1:0]   count;
  } result_t;

endpackage

FILE: rtl/spq_cell.sv
// One slot of the sorted shift chain: holds a task and compares it with the pushed one.
// Depends on spq_pkg.
module spq_cell (
  input  logic                       clk,
  input  spq_pkg::cell_ctrl_t        ctrl,
  input  logic                       occupied,
  input  logic [spq_pkg::PRIO_W-1:0] new_prio,
  input  logic [spq_pkg::PAY_W-1:0]  new_payload,
  input  logic                       prev_take,
  input  logic [spq_pkg::PRIO_W-1:0] prev_prio,
  input  logic [spq_pkg::PAY_W-1:0]  prev_payload,
  input  logic [spq_pkg::PRIO_W-1:0] next_prio,
  input  logic [spq_pkg::PAY_W-1:0]  next_payload,
  output logic                       take,
  output logic [spq_pkg::PRIO_W-1:0] prio,
  output logic [spq_pkg::PAY_W-1:0]  payload
);

  // The new task goes ahead of this slot unless a held task here is at least as urgent.
  assign take = !(occupied && (prio >= new_prio));

  always_ff @(posedge clk) begin
    if (ctrl.push && take) begin
      if (prev_take) begin
        prio    <= prev_prio;
        payload <= prev_payload;
      end else begin
        prio    <= new_prio;
        payload <= new_payload;
      end
    end else if (ctrl.pop) begin
      prio    <= next_prio;
      payload <= next_payload;
    end
  end

endmodule

FILE: rtl/spq_out_buf.sv
// Two-entry result buffer: an output register backed by a skid register.
// Depends on spq_pkg.
module spq_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  spq_pkg::result_t in_word,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output spq_pkg::result_t out_word
);

  logic             skid_valid;
  spq_pkg::result_t skid_word;
  logic             out_take;

  assign out_take = out_valid && !out_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        out_word   <= skid_word;
        skid_valid <= 1'b0;
      end
    end else if (in_valid) begin
      if (!out_valid || out_take) begin
        out_word  <= in_word;
        out_valid <= 1'b1;
      end else begin
        skid_word  <= in_word;
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: rtl/stable_priority_task_queue_unit.sv
// Stable priority task queue: up to DEPTH tasks kept sorted in a chain of cells, highest
// priority at the head and equal priorities in arrival order. Push, pop and stop each take
// one word per clock while task_stall is low; the result word is registered in the output
// buffer. Every cell compares its task with the pushed one in the same cycle and shifts in
// one step, so one operation per cycle is sustained unless task_stall is high. A two-entry
// output buffer lets the input keep flowing for one word while the result side is stalled.
`include "stable_priority_task_queue_unit_assert.svh"

module stable_priority_task_queue_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       task_valid,
  output logic                       task_stall,
  input  logic [1:0]                 op,
  input  logic [spq_pkg::PRIO_W-1:0] task_priority,
  input  logic [spq_pkg::PAY_W-1:0]  task_payload,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [2:0]                 status,
  output logic [spq_pkg::PRIO_W-1:0] out_priority,
  output logic [spq_pkg::PAY_W-1:0]  out_payload,
  output logic [spq_pkg::CNT_W-1:0]  entry_count
);

  localparam int DEPTH = spq_pkg::DEPTH;

  logic [spq_pkg::CNT_W-1:0]  held_count;
  logic [spq_pkg::CNT_W-1:0]  held_count_next;
  logic                       stop_flag;
  logic                       stop_flag_next;
  logic                       accept;
  logic                       two_held;
  spq_pkg::cell_ctrl_t        ctrl;
  spq_pkg::result_t           res;
  spq_pkg::result_t           out_word;
  spq_pkg::op_t               op_code;

  logic                       take [DEPTH];
  logic [spq_pkg::PRIO_W-1:0] cell_prio [DEPTH];
  logic [spq_pkg::PAY_W-1:0]  cell_payload [DEPTH];

  assign accept   = task_valid && !task_stall;
  assign op_code  = spq_pkg::op_t'(op);
  assign two_held = held_count >= spq_pkg::CNT_W'(2);

  always_comb begin
    ctrl            = '0;
    held_count_next = held_count;
    stop_flag_next  = stop_flag;
    res.status      = spq_pkg::ST_OK;
    res.prio        = '0;
    res.payload     = '0;
    unique case (op_code)
      spq_pkg::OP_PUSH: begin
        if (held_count == spq_pkg::CNT_W'(DEPTH)) begin
          res.status = spq_pkg::ST_PUSH_FULL;
        end else if (stop_flag) begin
          res.status = spq_pkg::ST_PUSH_STOPPED;
        end else begin
          ctrl.push       = accept;
          held_count_next = held_count + spq_pkg::CNT_W'(1);
        end
      end
      spq_pkg::OP_POP: begin
        if (held_count == '0) begin
          res.status = stop_flag ? spq_pkg::ST_POP_STOPPED : spq_pkg::ST_POP_EMPTY;
        end else begin
          ctrl.pop        = accept;
          res.prio        = cell_prio[0];
          res.payload     = cell_payload[0];
          held_count_next = held_count - spq_pkg::CNT_W'(1);
        end
      end
      spq_pkg::OP_STOP: begin
        stop_flag_next = 1'b1;
      end
      default: begin
      end
    endcase
    res.count = held_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      stop_flag  <= 1'b0;
    end else if (accept) begin
      held_count <= held_count_next;
      stop_flag  <= stop_flag_next;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                       prev_take;
    logic [spq_pkg::PRIO_W-1:0] prev_prio;
    logic [spq_pkg::PAY_W-1:0]  prev_payload;
    logic [spq_pkg::PRIO_W-1:0] next_prio;
    logic [spq_pkg::PAY_W-1:0]  next_payload;
    logic                       occupied;

    assign occupied = spq_pkg::CNT_W'(i) < held_count;

    if (i == 0) begin : g_head
      assign prev_take    = 1'b0;
      assign prev_prio    = '0;
      assign prev_payload = '0;
    end else begin : g_body
      assign prev_take    = take[i-1];
      assign prev_prio    = cell_prio[i-1];
      assign prev_payload = cell_payload[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_prio    = '0;
      assign next_payload = '0;
    end else begin : g_link
      assign next_prio    = cell_prio[i+1];
      assign next_payload = cell_payload[i+1];
    end

    spq_cell u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .occupied     (occupied),
      .new_prio     (task_priority),
      .new_payload  (task_payload),
      .prev_take    (prev_take),
      .prev_prio    (prev_prio),
      .prev_payload (prev_payload),
      .next_prio    (next_prio),
      .next_payload (next_payload),
      .take         (take[i]),
      .prio         (cell_prio[i]),
      .payload      (cell_payload[i])
    );
  end

  spq_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_word   (res),
    .full      (task_stall),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_word  (out_word)
  );

  assign status       = out_word.status;
  assign out_priority = out_word.prio;
  assign out_payload  = out_word.payload;
  assign entry_count  = out_word.count;

  `SPQ_NEVER(a_count_range, held_count > spq_pkg::CNT_W'(DEPTH), "held count above depth")
  `SPQ_ASSERT(a_stop_sticky, stop_flag |=> stop_flag, "stop flag cleared without reset")
  `SPQ_ASSERT(a_head_order, two_held |-> (cell_prio[0] >= cell_prio[1]), "head out of order")
  `SPQ_ASSERT(a_skid_behind_out, task_stall |-> result_valid, "skid word held with empty output")

endmodule
